@@ design/salru_pkg.sv @@
// ----------------------------------------------------------------------------
// salru_pkg: shared types and constants
// Widths, register indexes, controller states, the per-set row layout and divider ports.
// ----------------------------------------------------------------------------
`default_nettype none

package salru_pkg;

    localparam int MAX_SETS   = 256;
    localparam int MAX_WAYS   = 8;
    localparam int SET_W      = $clog2(MAX_SETS);
    localparam int WAY_W      = $clog2(MAX_WAYS);
    localparam int FILL_W     = $clog2(MAX_WAYS + 1);
    localparam int ADDR_W     = 31;
    localparam int DIV_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int SETS_REG_W = 9;
    localparam int WAYS_REG_W = 4;
    localparam int BW_REG_W   = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_COUNT   = 2'd0,
        CFG_WAY_COUNT   = 2'd1,
        CFG_BLOCK_WORDS = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_BLOCK,
        ST_DIV_SET,
        ST_READ,
        ST_UPDATE
    } ctrl_state_t;

    typedef struct packed {
        logic [MAX_WAYS-1:0][ADDR_W-1:0] tags;
        logic [MAX_WAYS-1:0][WAY_W-1:0]  ranks;
        logic [FILL_W-1:0]               fill;
    } set_row_t;

    typedef struct packed {
        logic              start;
        logic [ADDR_W-1:0] dividend;
        logic [DIV_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic              busy;
        logic [ADDR_W-1:0] quotient;
        logic [DIV_W-1:0]  remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

@@ design/salru_if.sv @@
// ----------------------------------------------------------------------------
// salru channel interfaces
// Request, response and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface salru_req_if import salru_pkg::*;;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] word_address;
    modport source (output valid, output word_address, input ready);
    modport sink   (input valid, input word_address, output ready);
endinterface

interface salru_rsp_if;
    logic valid;
    logic ready;
    logic hit;
    modport source (output valid, output hit, input ready);
    modport sink   (input valid, input hit, output ready);
endinterface

interface salru_cfg_if import salru_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/salru_div.sv @@
// ----------------------------------------------------------------------------
// salru_div: radix-2 restoring divider
// One quotient bit per cycle; quotient and remainder hold until next start.
// ----------------------------------------------------------------------------
`default_nettype none

module salru_div import salru_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int CNT_W = $clog2(ADDR_W + 1);

    logic [ADDR_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  dvs_reg, dvs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_W:0]    trial;
    logic              ge;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[ADDR_W-1]};
        ge        = (trial >= {1'b0, dvs_reg});
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            // shift in one dividend bit, subtract when it fits
            quo_next = {quo_reg[ADDR_W-2:0], ge};
            rem_next = ge ? DIV_W'(trial - {1'b0, dvs_reg}) : trial[DIV_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = CNT_W'(ADDR_W);
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.busy      = busy_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

@@ design/salru_set_mem.sv @@
// ----------------------------------------------------------------------------
// salru_set_mem: per-set row memory
// One row per set, registered read; a never-written set reads empty.
// ----------------------------------------------------------------------------
`default_nettype none

module salru_set_mem import salru_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             rd_en,
    input  wire logic [SET_W-1:0] rd_addr,
    output set_row_t              rd_row,
    input  wire logic             wr_en,
    input  wire logic [SET_W-1:0] wr_addr,
    input  wire set_row_t         wr_row
);

    set_row_t              mem [MAX_SETS];
    logic [MAX_SETS-1:0]   valid_reg;
    set_row_t              rd_data_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_row;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_comb
    begin
        rd_row = rd_data_reg;
        if (!rd_valid_reg)
        begin
            rd_row.fill = '0;
        end
    end

endmodule

`default_nettype wire

@@ design/salru_lru_upd.sv @@
// ----------------------------------------------------------------------------
// salru_lru_upd: recency update for one set
// Tag compare across the ways, then hit promotion or miss insertion.
// ----------------------------------------------------------------------------
`default_nettype none

module salru_lru_upd import salru_pkg::*;
(
    input  wire set_row_t              row,
    input  wire logic [ADDR_W-1:0]     tag,
    input  wire logic [WAYS_REG_W-1:0] ways,
    output set_row_t                   row_new,
    output logic                       hit
);

    logic [WAY_W-1:0]  hit_slot;
    logic [WAY_W-1:0]  hit_rank;
    logic [WAY_W-1:0]  vic_slot;
    logic [WAY_W-1:0]  last_rank;
    logic [WAY_W-1:0]  ins_slot;
    logic              full;
    logic [FILL_W-1:0] fill;

    always_comb
    begin
        fill      = row.fill;
        hit       = 1'b0;
        hit_slot  = '0;
        vic_slot  = '0;
        last_rank = WAY_W'(fill - FILL_W'(1));
        full      = ({1'b0, fill} >= (FILL_W+1)'(ways)) && (fill != '0);
        for (int k = MAX_WAYS - 1; k >= 0; k--)
        begin
            if ((FILL_W'(k) < fill) && (row.tags[k] == tag))
            begin
                hit      = 1'b1;
                hit_slot = WAY_W'(k);
            end
        end
        for (int k = 0; k < MAX_WAYS; k++)
        begin
            if ((FILL_W'(k) < fill) && (row.ranks[k] == last_rank))
            begin
                vic_slot = WAY_W'(k);
            end
        end
        hit_rank = row.ranks[hit_slot];
        ins_slot = full ? vic_slot : WAY_W'(fill);

        row_new = row;
        if (hit)
        begin
            // promote: age everything younger than the hit entry
            for (int j = 0; j < MAX_WAYS; j++)
            begin
                if ((FILL_W'(j) < fill) && (row.ranks[j] < hit_rank))
                begin
                    row_new.ranks[j] = row.ranks[j] + WAY_W'(1);
                end
            end
            row_new.ranks[hit_slot] = '0;
        end
        else
        begin
            // age all live entries, drop the oldest when full
            for (int j = 0; j < MAX_WAYS; j++)
            begin
                if ((FILL_W'(j) < fill) && !(full && (WAY_W'(j) == vic_slot)))
                begin
                    row_new.ranks[j] = row.ranks[j] + WAY_W'(1);
                end
            end
            row_new.tags[ins_slot]  = tag;
            row_new.ranks[ins_slot] = '0;
            if (!full)
            begin
                row_new.fill = fill + FILL_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ design/set_assoc_lru_cache_lookup_unit.sv @@
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup_unit: set-associative LRU cache lookup
//
// Usage:
//   req : one word address per request (valid/ready). Ready is high only
//         while the unit is idle; one request is in flight at a time.
//   rsp : one hit flag per request, held in an output register until the
//         receiver takes it. A stalled receiver holds the unit in its update
//         step; a new request is still taken while the old response waits.
//   cfg : always ready; write set_count, way_count, block_words by index.
//         Write only while the unit is idle.
// Steps: accept the request, divide the address by block_words, divide the
//   block address by set_count, then one memory read and one read-modify-write
//   of the set row. Both divisions run on the shared one-bit-per-cycle divider,
//   and the next request is taken only after the response has been
//   registered.
// Reset: registers go to 1, every set reads empty; no clearing pass is run.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_lru_cache_lookup_unit import salru_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    salru_req_if.sink  req,
    salru_rsp_if.source rsp,
    salru_cfg_if.sink  cfg
);

    ctrl_state_t           state_reg, state_next;
    logic [SETS_REG_W-1:0] set_count_reg;
    logic [WAYS_REG_W-1:0] way_count_reg;
    logic [BW_REG_W-1:0]   block_words_reg;
    logic [ADDR_W-1:0]     tag_reg, tag_next;
    logic [SET_W-1:0]      set_reg, set_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic                  hit_reg, hit_next;

    logic [SETS_REG_W-1:0] sets_eff;
    logic [WAYS_REG_W-1:0] ways_eff;
    logic [BW_REG_W-1:0]   bw_eff;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic       mem_rd_en;
    logic       mem_wr_en;
    set_row_t   row_rd;
    set_row_t   row_wr;
    logic       lookup_hit;

    // Zero registers act as 1, oversized ones saturate
    always_comb
    begin
        sets_eff = set_count_reg;
        if (set_count_reg == '0)
        begin
            sets_eff = SETS_REG_W'(1);
        end
        else if (set_count_reg > SETS_REG_W'(MAX_SETS))
        begin
            sets_eff = SETS_REG_W'(MAX_SETS);
        end
        ways_eff = way_count_reg;
        if (way_count_reg == '0)
        begin
            ways_eff = WAYS_REG_W'(1);
        end
        else if (way_count_reg > WAYS_REG_W'(MAX_WAYS))
        begin
            ways_eff = WAYS_REG_W'(MAX_WAYS);
        end
        bw_eff = (block_words_reg == '0) ? BW_REG_W'(1) : block_words_reg;
    end

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_count_reg   <= SETS_REG_W'(1);
            way_count_reg   <= WAYS_REG_W'(1);
            block_words_reg <= BW_REG_W'(1);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_SET_COUNT:   set_count_reg   <= cfg.data[SETS_REG_W-1:0];
                CFG_WAY_COUNT:   way_count_reg   <= cfg.data[WAYS_REG_W-1:0];
                CFG_BLOCK_WORDS: block_words_reg <= cfg.data[BW_REG_W-1:0];
                default:         ;
            endcase
        end
    end

    salru_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    salru_set_mem u_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (set_reg),
        .rd_row  (row_rd),
        .wr_en   (mem_wr_en),
        .wr_addr (set_reg),
        .wr_row  (row_wr)
    );

    salru_lru_upd u_upd
    (
        .row     (row_rd),
        .tag     (tag_reg),
        .ways    (ways_eff),
        .row_new (row_wr),
        .hit     (lookup_hit)
    );

    always_comb
    begin
        state_next       = state_reg;
        tag_next         = tag_reg;
        set_next         = set_reg;
        rsp_valid_next   = rsp_valid_reg;
        hit_next         = hit_reg;
        div_req.start    = 1'b0;
        div_req.dividend = req.word_address;
        div_req.divisor  = DIV_W'(bw_eff);
        mem_rd_en        = 1'b0;
        mem_wr_en        = 1'b0;
        req.ready        = 1'b0;

        // drop the response once taken
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                req.ready     = 1'b1;
                div_req.start = req.valid;
                if (req.valid)
                begin
                    state_next = ST_DIV_BLOCK;
                end
            end
            ST_DIV_BLOCK:
            begin
                // block address -> set and tag
                div_req.dividend = div_rsp.quotient;
                div_req.divisor  = DIV_W'(sets_eff);
                if (div_rsp.done)
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV_SET;
                end
            end
            ST_DIV_SET:
            begin
                if (div_rsp.done)
                begin
                    tag_next   = div_rsp.quotient;
                    set_next   = div_rsp.remainder[SET_W-1:0];
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                mem_rd_en  = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // hold until the output register is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    mem_wr_en      = 1'b1;
                    rsp_valid_next = 1'b1;
                    hit_next       = lookup_hit;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
        set_reg <= set_next;
        hit_reg <= hit_next;
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.hit   = hit_reg;

endmodule

`default_nettype wire

@@ verif/salru_hit_scoreboard.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// salru_hit_scoreboard: LRU lookup predictor and hit-flag comparator
// Watches the request, response and config channels, keeps a private copy
// of the tag store, recency ranks and set fill, and checks every hit flag.
// ----------------------------------------------------------------------------
`default_nettype none

module salru_hit_scoreboard import salru_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    salru_req_if      req,
    salru_rsp_if      rsp,
    salru_cfg_if      cfg,
    output int        err_count,
    output int        pending_hits,
    output int        lookups_done,
    output int        hits_seen
);

    logic [ADDR_W-1:0]     tag_mem   [MAX_SETS][MAX_WAYS];
    logic [WAY_W-1:0]      rank_mem  [MAX_SETS][MAX_WAYS];
    logic [FILL_W-1:0]     fill_mem  [MAX_SETS];
    logic [SETS_REG_W-1:0] sets_reg;
    logic [WAYS_REG_W-1:0] ways_reg;
    logic [BW_REG_W-1:0]   bw_reg;
    bit                    hit_queue [$];

    // Look up one address, update the LRU state, return the hit flag.
    function automatic bit lru_lookup(input logic [ADDR_W-1:0] addr);
        int unsigned sets;
        int unsigned ways;
        int unsigned bw;
        int unsigned blk;
        int unsigned set_i;
        int unsigned tag;
        int unsigned fill;
        int unsigned slot;
        logic [WAY_W-1:0] r;
        sets = (sets_reg == 0) ? 1 : (sets_reg > MAX_SETS) ? MAX_SETS : sets_reg;
        ways = (ways_reg == 0) ? 1 : (ways_reg > MAX_WAYS) ? MAX_WAYS : ways_reg;
        bw   = (bw_reg == 0) ? 1 : bw_reg;
        blk   = addr / bw;
        set_i = blk % sets;
        tag   = blk / sets;
        fill  = fill_mem[set_i];
        if (fill > MAX_WAYS)
            fill = MAX_WAYS;
        for (int k = 0; k < fill; k++)
        begin
            if (tag_mem[set_i][k] == tag)
            begin
                r = rank_mem[set_i][k];
                for (int j = 0; j < fill; j++)
                    if (rank_mem[set_i][j] < r)
                        rank_mem[set_i][j]++;
                rank_mem[set_i][k] = 0;
                return 1'b1;
            end
        end
        if (fill >= ways && fill > 0)
        begin
            // full (or over-full after a ways reduction): replace least recent
            slot = 0;
            for (int k = 0; k < fill; k++)
                if (rank_mem[set_i][k] == WAY_W'(fill - 1))
                    slot = k;
            for (int k = 0; k < fill; k++)
                if (k != slot)
                    rank_mem[set_i][k]++;
        end
        else
        begin
            slot = fill;
            for (int k = 0; k < fill; k++)
                rank_mem[set_i][k]++;
            fill_mem[set_i] = FILL_W'(fill + 1);
        end
        tag_mem[set_i][slot]  = tag;
        rank_mem[set_i][slot] = 0;
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bit want;
        if (!rst_n)
        begin
            sets_reg = 1;
            ways_reg = 1;
            bw_reg   = 1;
            foreach (fill_mem[s])
                fill_mem[s] = '0;
            hit_queue.delete();
            err_count    <= 0;
            pending_hits <= 0;
            lookups_done <= 0;
            hits_seen    <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg_idx_t'(cfg.index))
                    CFG_SET_COUNT:   sets_reg = cfg.data[SETS_REG_W-1:0];
                    CFG_WAY_COUNT:   ways_reg = cfg.data[WAYS_REG_W-1:0];
                    CFG_BLOCK_WORDS: bw_reg   = cfg.data[BW_REG_W-1:0];
                    default: ;
                endcase
            end
            if (rsp.valid && rsp.ready)
            begin
                if (hit_queue.size() == 0)
                begin
                    $display("%0t ERROR: response hit=%0b with no request pending",
                             $time, rsp.hit);
                    err_count <= err_count + 1;
                end
                else
                begin
                    want = hit_queue.pop_front();
                    if (rsp.hit !== want)
                    begin
                        $display("%0t ERROR: hit expected %0b actual %0b",
                                 $time, want, rsp.hit);
                        err_count <= err_count + 1;
                    end
                    lookups_done <= lookups_done + 1;
                    hits_seen    <= hits_seen + int'(want);
                end
            end
            if (req.valid && req.ready)
                hit_queue.insert(hit_queue.size(), lru_lookup(req.word_address));
            pending_hits <= hit_queue.size();
        end
    end

endmodule

`default_nettype wire

@@ verif/set_assoc_lru_cache_lookup_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup_unit_tb: regression for the LRU lookup unit
// Drives word-address requests in bursts through several cache shapes,
// stalls the hit-flag receiver, and reports the scoreboard verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_lru_cache_lookup_unit_tb import salru_pkg::*;;

    localparam int IDLE_LIMIT = 5000;   // cycles with no handshake at all

    logic clk;
    logic rst_n;

    salru_req_if req_ch ();
    salru_rsp_if rsp_ch ();
    salru_cfg_if cfg_ch ();

    int err_count;
    int pending_hits;
    int lookups_done;
    int hits_seen;
    int cfg_writes;
    int idle_cycles;
    int cycle_no;
    int hold_left;
    int stall_mode;

    logic [ADDR_W-1:0] hot_addr [16];

    set_assoc_lru_cache_lookup_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source),
        .cfg   (cfg_ch.sink)
    );

    salru_hit_scoreboard u_scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_ch),
        .rsp          (rsp_ch),
        .cfg          (cfg_ch),
        .err_count    (err_count),
        .pending_hits (pending_hits),
        .lookups_done (lookups_done),
        .hits_seen    (hits_seen)
    );

    // 12 ns clock
    initial
        clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Receiver: switch among four stall patterns at random; once, early
    // in the random part, hold off for a long stretch so requests back up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            cycle_no     <= 0;
            hold_left    <= 0;
            stall_mode   <= 0;
        end
        else
        begin
            cycle_no <= cycle_no + 1;
            if (cycle_no % 300 == 0)
                stall_mode <= $urandom_range(0, 3);
            if (cycle_no == 8000)
            begin
                hold_left    <= 900;
                rsp_ch.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left    <= hold_left - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= $urandom_range(0, 1);
                    2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ch.ready <= ($urandom_range(0, 15) != 0);
                endcase
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("%0t watchdog expired", $time);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offer one request and hold it until taken; valid stays high afterwards.
    task automatic issue_lookup(input logic [ADDR_W-1:0] addr);
        req_ch.valid        <= 1'b1;
        req_ch.word_address <= addr;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Drop valid and wait a random gap.
    task automatic pause_sender(input int max_gap);
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(1, max_gap))
            @(posedge clk);
    endtask

    // Wait until every hit flag is back, then let the unit settle.
    task automatic drain_lookups();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_hits != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    // Write one register; valid stays high for the next write.
    task automatic write_reg(input cfg_idx_t idx, input int unsigned value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= CFG_DATA_W'(value);
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_writes++;
    endtask

    task automatic set_shape(input int unsigned sets, input int unsigned ways,
                             input int unsigned bw);
        drain_lookups();
        write_reg(CFG_SET_COUNT, sets);
        write_reg(CFG_WAY_COUNT, ways);
        write_reg(CFG_BLOCK_WORDS, bw);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        int unsigned sets;
        int unsigned ways;
        int unsigned bw;
        int unsigned burst;
        int unsigned sent;
        logic [ADDR_W-1:0] addr;

        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.word_address = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = CFG_SET_COUNT;
        cfg_ch.data         = '0;
        cfg_writes          = 0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset shape, extreme addresses, repeat hits.
        issue_lookup('0);
        issue_lookup('0);
        issue_lookup('1);
        issue_lookup('1);
        issue_lookup('0);

        // Zero registers act as one.
        set_shape(0, 0, 0);
        issue_lookup(31'd5);
        issue_lookup(31'd5);
        issue_lookup(31'd6);

        // Registers above the maximum clamp; largest block size.
        set_shape(511, 15, 127);
        issue_lookup('1);
        issue_lookup(31'h7FFF_FF00);
        issue_lookup('1);
        set_shape(256, 8, 64);
        issue_lookup('1);
        issue_lookup(31'd64 * 31'd256);

        // Fill set 0 with eight tags, then reduce ways: misses evict one only.
        set_shape(4, 8, 1);
        for (int k = 0; k < 8; k++)
            issue_lookup(31'(k * 4));
        set_shape(4, 2, 1);
        issue_lookup(31'd32);
        issue_lookup(31'd28);
        issue_lookup(31'd4);

        // Shrink the set count, then grow it back: set rows are kept across the change.
        set_shape(1, 2, 1);
        issue_lookup(31'd1000);
        set_shape(4, 2, 1);
        issue_lookup(31'd28);
        issue_lookup(31'd32);

        // Random phases: mostly reuse of a hot address pool, some noise.
        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase % 4)
                0:       sets = 256;
                1:       sets = 1;
                2:       sets = $urandom_range(0, 511);
                default: sets = $urandom_range(1, 16);
            endcase
            ways = (phase == 1) ? 8 : $urandom_range(0, 15);
            bw   = (phase == 0) ? 64 : $urandom_range(0, 127);
            set_shape(sets, ways, bw);
            foreach (hot_addr[i])
                hot_addr[i] = ($urandom_range(0, 1) != 0) ? 31'($urandom_range(0, 4095))
                                                          : 31'($urandom);
            sent = 0;
            while (sent < 185)
            begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst; b++)
                begin
                    if ($urandom_range(0, 3) == 0)
                        addr = 31'($urandom);
                    else
                        addr = hot_addr[$urandom_range(0, 15)]
                               + 31'($urandom_range(0, 3 * 128));
                    issue_lookup(addr);
                    sent++;
                end
                if ($urandom_range(0, 2) != 0)
                    pause_sender(150);
            end
        end

        drain_lookups();
        repeat (80)
            @(posedge clk);

        $display("Covered %0d lookups (%0d hits) over %0d register writes,",
                 lookups_done, hits_seen, cfg_writes);
        $display("including clamped, zero and reduced-way cache shapes.");
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
